// ===== hdl/imu_motion_displacement_core_macros.svh =====
// Assertion macros for the motion displacement core.
// Included by the top level; no other dependencies.
`ifndef IMU_MOTION_DISPLACEMENT_CORE_MACROS_SVH
`define IMU_MOTION_DISPLACEMENT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/imd_pkg.sv =====
// Shared constants and types for the motion displacement core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package imd_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DISP_WIDTH   = 35;
   localparam int Q16_W        = 17;
   localparam int SQ_W         = 62;
   localparam int GSQ_W        = 31;
   localparam int ROOT_W       = 31;
   localparam int D_W          = 27;

   // round(9.81 * 2^26): converts raw LSB (16384 per g) to m/s^2 with 24 fraction bits.
   localparam logic [29:0] ACCEL_MUL   = 30'd658337956;
   // 0.005 s in Q0.32.
   localparam logic [24:0] HALF_DT_Q32 = 25'd21474836;
   localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic load;
      logic grav;
      logic resid;
      logic square;
      logic scale;
      logic vel;
      logic disp;
   } lane_cmd_type;

endpackage

// ===== hdl/imd_if.sv =====
// Handshake channels of the motion displacement core: sample request and result.
// Depends on imd_pkg.
`timescale 1ns / 1ps

interface imd_req_if;
   import imd_pkg::*;
   logic valid;
   logic ready;
   logic signed [SAMPLE_WIDTH-1:0] accel_x;
   logic signed [SAMPLE_WIDTH-1:0] accel_y;
   logic signed [SAMPLE_WIDTH-1:0] accel_z;
   logic signed [SAMPLE_WIDTH-1:0] gyro_x;
   logic signed [SAMPLE_WIDTH-1:0] gyro_y;
   logic signed [SAMPLE_WIDTH-1:0] gyro_z;
   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 output ready);
endinterface

interface imd_rsp_if;
   import imd_pkg::*;
   logic valid;
   logic ready;
   logic signed [DISP_WIDTH-1:0] disp_x;
   logic signed [DISP_WIDTH-1:0] disp_y;
   logic signed [DISP_WIDTH-1:0] disp_z;
   logic is_stationary;
   logic [1:0] rotation_band;
   modport source (output valid, disp_x, disp_y, disp_z, is_stationary, rotation_band,
                   input ready);
   modport sink (input valid, disp_x, disp_y, disp_z, is_stationary, rotation_band,
                 output ready);
endinterface

// ===== hdl/imd_axis_lane.sv =====
// One axis lane: unit conversion, gravity filter, squares, weighting and trapezoidal steps.
// Depends on imd_pkg.
`timescale 1ns / 1ps

module imd_axis_lane (
   input  logic                                      clock,
   input  logic                                      reset,
   input  imd_pkg::lane_cmd_type                     cmd,
   input  logic signed [imd_pkg::SAMPLE_WIDTH-1:0]   accel_raw,
   input  logic signed [imd_pkg::SAMPLE_WIDTH-1:0]   gyro_raw,
   input  logic [imd_pkg::Q16_W-1:0]                 coeff,
   input  logic [imd_pkg::Q16_W-1:0]                 weight,
   output logic [imd_pkg::SQ_W-1:0]                  accel_sq,
   output logic [imd_pkg::GSQ_W-1:0]                 gyro_sq,
   output logic signed [imd_pkg::D_W-1:0]            disp_step
);
   import imd_pkg::*;

   logic signed [30:0] a_ff, a_in;
   logic signed [30:0] grav_ff, grav_in;
   logic signed [31:0] res_ff, res_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [GSQ_W-1:0]   gsq_ff, gsq_in;
   logic signed [31:0] sa_ff, sa_in, psa_ff;
   logic signed [26:0] v_ff, v_in, pv_ff;
   logic signed [D_W-1:0] d_ff, d_in;

   logic signed [46:0] a_prod, a_rnd;
   logic signed [31:0] g_prod;
   logic signed [31:0] g_diff;
   logic signed [49:0] g_mul, g_rnd;
   logic [30:0]        res_abs;
   logic signed [31:0] res_neg;
   logic signed [49:0] s_mul, s_rnd;
   logic signed [32:0] v_sum;
   logic signed [58:0] v_mul, v_rnd;
   logic signed [27:0] d_sum;

   always_comb begin
      // Conversion to m/s^2, rounded half up.
      a_prod = 47'(accel_raw) * 47'($signed({1'b0, ACCEL_MUL}));
      a_rnd  = a_prod + 47'sd32768;
      a_in   = a_rnd[46:16];
      g_prod = 32'(gyro_raw) * 32'(gyro_raw);
      gsq_in = g_prod[GSQ_W-1:0];
      // Gravity low-pass step towards the new sample.
      g_diff  = 32'(a_ff) - 32'(grav_ff);
      g_mul   = 50'(g_diff) * 50'($signed({1'b0, coeff}));
      g_rnd   = g_mul + 50'sd32768;
      grav_in = grav_ff + $signed(g_rnd[46:16]);
      res_in  = 32'(a_ff) - 32'(grav_ff);
      res_neg = -res_ff;
      res_abs = res_ff[31] ? res_neg[30:0] : res_ff[30:0];
      sq_in   = SQ_W'(res_abs) * SQ_W'(res_abs);
      // Band weighting.
      s_mul = 50'(res_ff) * 50'($signed({1'b0, weight}));
      s_rnd = s_mul + 50'sd32768;
      sa_in = s_rnd[47:16];
      // First trapezoidal step: velocity increment.
      v_sum = 33'(psa_ff) + 33'(sa_ff);
      v_mul = 59'(v_sum) * 59'($signed({1'b0, HALF_DT_Q32}));
      v_rnd = v_mul + 59'sd2147483648;
      v_in  = v_rnd[58:32];
      // Second trapezoidal step: displacement increment.
      d_sum = 28'(pv_ff) + 28'(v_ff) + 28'sd1;
      d_in  = d_sum[27:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= '0;
         psa_ff  <= '0;
         pv_ff   <= '0;
      end else begin
         if (cmd.grav) grav_ff <= grav_in;
         if (cmd.disp) begin
            psa_ff <= sa_ff;
            pv_ff  <= v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff   <= a_in;
         gsq_ff <= gsq_in;
      end
      if (cmd.resid)  res_ff <= res_in;
      if (cmd.square) sq_ff  <= sq_in;
      if (cmd.scale)  sa_ff  <= sa_in;
      if (cmd.vel)    v_ff   <= v_in;
      if (cmd.disp)   d_ff   <= d_in;
   end

   assign accel_sq  = sq_ff;
   assign gyro_sq   = gsq_ff;
   assign disp_step = d_ff;

endmodule

// ===== hdl/imd_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle, truncated result.
// Depends on imd_pkg.
`timescale 1ns / 1ps

module imd_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [imd_pkg::SQ_W-1:0]     radicand,
   output logic                         done,
   output logic [imd_pkg::ROOT_W-1:0]   root
);
   import imd_pkg::*;

   localparam int STEPS = SQ_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0]  val_ff, val_in;
   logic [31:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [33:0]      rem_sh, trial, rem_sub;

   always_comb begin
      rem_sh  = {rem_ff, val_ff[SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sub[31:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[31:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hdl/imd_kalman.sv =====
// Scalar Kalman filter on the residual acceleration magnitude, with a serial gain divider.
// Depends on imd_pkg.
`timescale 1ns / 1ps

module imd_kalman (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [imd_pkg::ROOT_W-1:0]   mag,
   input  logic [23:0]                  process_noise,
   input  logic [23:0]                  measure_noise,
   input  logic [23:0]                  still_threshold,
   output logic                         done,
   output logic                         still
);
   import imd_pkg::*;

   typedef enum logic [4:0] {
      K_IDLE = 5'b00001,
      K_PREP = 5'b00010,
      K_DIV  = 5'b00100,
      K_EST  = 5'b01000,
      K_DONE = 5'b10000
   } kstate_type;

   kstate_type state_ff, state_in;
   logic [ROOT_W-1:0]  mag_ff;
   logic [31:0]        var_ff, var_in, p_ff;
   logic signed [32:0] est_ff, est_in;
   logic [32:0]        rem_ff, rem_in, p_sum, den;
   logic [33:0]        rem_sh, rem_sub;
   logic [15:0]        q_ff, q_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [31:0]        p_sat;
   logic [Q16_W-1:0]   k_val;
   logic signed [33:0] e_diff;
   logic signed [51:0] e_mul, e_rnd;
   logic [48:0]        v_mul;

   always_comb begin
      p_sum   = {1'b0, var_ff} + 33'(process_noise);
      p_sat   = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
      den     = {1'b0, p_ff} + 33'(measure_noise);
      rem_sh  = {rem_ff, 1'b0};
      rem_sub = rem_sh - {1'b0, den};
      // With no measurement noise the gain is one, unless the denominator is zero.
      if (measure_noise == 24'd0)
         k_val = (p_ff == 32'd0) ? '0 : ONE_Q16;
      else
         k_val = {1'b0, q_ff};
      e_diff = 34'($signed({1'b0, mag_ff})) - 34'(est_ff);
      e_mul  = 52'(e_diff) * 52'($signed({1'b0, k_val}));
      e_rnd  = e_mul + 52'sd32768;
      v_mul  = 49'(ONE_Q16 - k_val) * 49'(p_ff);

      state_in = state_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      est_in   = est_ff;
      var_in   = var_ff;
      case (state_ff)
         K_IDLE: begin
            if (start) state_in = K_PREP;
         end
         K_PREP: begin
            rem_in   = {1'b0, p_sat};
            q_in     = '0;
            cnt_in   = '0;
            state_in = K_DIV;
         end
         K_DIV: begin
            if (rem_sh >= {1'b0, den}) begin
               rem_in = rem_sub[32:0];
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh[32:0];
               q_in   = {q_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) state_in = K_EST;
         end
         K_EST: begin
            est_in   = est_ff + $signed(e_rnd[48:16]);
            var_in   = v_mul[47:16];
            state_in = K_DONE;
         end
         K_DONE: begin
            state_in = K_IDLE;
         end
         default: begin
            state_in = K_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= K_IDLE;
         var_ff   <= '0;
         est_ff   <= '0;
      end else begin
         state_ff <= state_in;
         var_ff   <= var_in;
         est_ff   <= est_in;
      end
      if (state_ff == K_IDLE && start) mag_ff <= mag;
      if (state_ff == K_PREP) p_ff <= p_sat;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done  = (state_ff == K_DONE);
   assign still = est_ff < $signed({1'b0, still_threshold, 8'b0});

endmodule

// ===== hdl/imu_motion_displacement_core.sv =====
// Motion displacement core: takes one accelerometer and gyro word per sample tick and
// returns summed displacement once per window. Depends on imd_pkg, imd_if, imd_axis_lane,
// imd_isqrt, imd_kalman and the macro header. Three axis lanes work side by side on a
// word; a merging stage sums their squared residuals, takes the square root (one result
// bit per cycle), runs the Kalman filter (serial gain divider) and hands the band weight
// back to the lanes. The next word can be taken only once the last one has gone through
// every step, a time set mostly by the square root and the divider; req_chan.ready
// is high only between words. A finished window result sits in an output register, so the
// core carries on with the next word while the result waits; only a second result arriving
// before the first is taken makes the core wait. The window length register defines how
// many words are summed; the word after a full window emits the totals and clears them.
`timescale 1ns / 1ps

`include "imu_motion_displacement_core_macros.svh"

module imu_motion_displacement_core (
   input  logic         clock,
   input  logic         reset,
   imd_req_if.sink      req_chan,
   imd_rsp_if.source    rsp_chan,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import imd_pkg::*;

   // Register map.
   typedef enum logic [2:0] {
      CSR_GRAVITY_COEFF   = 3'd0,
      CSR_PROCESS_NOISE   = 3'd1,
      CSR_MEASURE_NOISE   = 3'd2,
      CSR_STILL_THRESHOLD = 3'd3,
      CSR_SLOW_LIMIT      = 3'd4,
      CSR_FAST_LIMIT      = 3'd5,
      CSR_SLOW_WEIGHT     = 3'd6,
      CSR_WINDOW_LENGTH   = 3'd7
   } csr_index_type;

   localparam logic [1:0] BAND_NONE = 2'd0;
   localparam logic [1:0] BAND_SLOW = 2'd1;
   localparam logic [1:0] BAND_FAST = 2'd2;

   // Sequencer of one word; each state is one step of the lanes or the merging stage.
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_GRAV   = 11'b00000000010,
      ST_RESID  = 11'b00000000100,
      ST_SQUARE = 11'b00000001000,
      ST_SUMSQ  = 11'b00000010000,
      ST_ROOT   = 11'b00000100000,
      ST_KALMAN = 11'b00001000000,
      ST_SCALE  = 11'b00010000000,
      ST_VEL    = 11'b00100000000,
      ST_DISP   = 11'b01000000000,
      ST_SUM    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [Q16_W-1:0] gravity_coeff_ff, slow_weight_ff;
   logic [23:0]      process_noise_ff, measure_noise_ff, still_threshold_ff;
   logic [15:0]      slow_limit_ff, fast_limit_ff;
   logic [9:0]       window_length_ff;

   logic             req_accept;
   lane_cmd_type     lane_cmd;
   logic [Q16_W-1:0] coeff_eff, weight_eff, weight;
   logic signed [SAMPLE_WIDTH-1:0] accel_raw [3];
   logic signed [SAMPLE_WIDTH-1:0] gyro_raw  [3];
   logic [SQ_W-1:0]  accel_sq  [3];
   logic [GSQ_W-1:0] gyro_sq   [3];
   logic signed [D_W-1:0] disp_step [3];

   logic [SQ_W-1:0]  sumsq;
   logic [31:0]      gsq_total, slow2, fast2;
   logic [1:0]       band, band_ff;
   logic             root_done, kal_done, kal_still, still_ff;
   logic [ROOT_W-1:0] root_val;

   logic [9:0]       tick_ff;
   logic signed [DISP_WIDTH-1:0] total_ff [3];
   logic signed [DISP_WIDTH-1:0] total_sat [3];
   logic signed [DISP_WIDTH:0]   total_sum [3];
   logic             emit, stall;
   logic             rsp_valid_ff;
   logic signed [DISP_WIDTH-1:0] rsp_disp_ff [3];
   logic             rsp_still_ff;
   logic [1:0]       rsp_band_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_coeff_ff   <= 17'd13107;
         process_noise_ff   <= 24'd13107;
         measure_noise_ff   <= 24'd13107;
         still_threshold_ff <= 24'd65536;
         slow_limit_ff      <= 16'd820;
         fast_limit_ff      <= 16'd1640;
         slow_weight_ff     <= 17'd13107;
         window_length_ff   <= 10'd100;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRAVITY_COEFF:   gravity_coeff_ff   <= csr_wdata[Q16_W-1:0];
            CSR_PROCESS_NOISE:   process_noise_ff   <= csr_wdata;
            CSR_MEASURE_NOISE:   measure_noise_ff   <= csr_wdata;
            CSR_STILL_THRESHOLD: still_threshold_ff <= csr_wdata;
            CSR_SLOW_LIMIT:      slow_limit_ff      <= csr_wdata[15:0];
            CSR_FAST_LIMIT:      fast_limit_ff      <= csr_wdata[15:0];
            CSR_SLOW_WEIGHT:     slow_weight_ff     <= csr_wdata[Q16_W-1:0];
            CSR_WINDOW_LENGTH:   window_length_ff   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign accel_raw[0] = req_chan.accel_x;
   assign accel_raw[1] = req_chan.accel_y;
   assign accel_raw[2] = req_chan.accel_z;
   assign gyro_raw[0]  = req_chan.gyro_x;
   assign gyro_raw[1]  = req_chan.gyro_y;
   assign gyro_raw[2]  = req_chan.gyro_z;

   // Weights above one act as one.
   assign coeff_eff  = (gravity_coeff_ff > ONE_Q16) ? ONE_Q16 : gravity_coeff_ff;
   assign weight_eff = (slow_weight_ff > ONE_Q16) ? ONE_Q16 : slow_weight_ff;

   always_comb begin
      lane_cmd        = '0;
      lane_cmd.load   = req_accept;
      lane_cmd.grav   = (state_ff == ST_GRAV);
      lane_cmd.resid  = (state_ff == ST_RESID);
      lane_cmd.square = (state_ff == ST_SQUARE);
      lane_cmd.scale  = (state_ff == ST_SCALE);
      lane_cmd.vel    = (state_ff == ST_VEL);
      lane_cmd.disp   = (state_ff == ST_DISP);
   end

   // Still or fast rotation removes the acceleration; band one scales it.
   always_comb begin
      if (still_ff || band_ff == BAND_FAST)
         weight = '0;
      else if (band_ff == BAND_NONE)
         weight = ONE_Q16;
      else
         weight = weight_eff;
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      imd_axis_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (lane_cmd),
         .accel_raw (accel_raw[i]),
         .gyro_raw  (gyro_raw[i]),
         .coeff     (coeff_eff),
         .weight    (weight),
         .accel_sq  (accel_sq[i]),
         .gyro_sq   (gyro_sq[i]),
         .disp_step (disp_step[i])
      );
   end

   // Merging stage: the squared magnitudes of the three lanes are combined here and the rotation band is chosen.
   always_comb begin
      sumsq     = accel_sq[0] + accel_sq[1] + accel_sq[2];
      gsq_total = 32'(gyro_sq[0]) + 32'(gyro_sq[1]) + 32'(gyro_sq[2]);
      slow2     = 32'(slow_limit_ff) * 32'(slow_limit_ff);
      fast2     = 32'(fast_limit_ff) * 32'(fast_limit_ff);
      if (gsq_total < slow2)
         band = BAND_NONE;
      else if (gsq_total < fast2)
         band = BAND_SLOW;
      else
         band = BAND_FAST;
   end

   imd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SUMSQ),
      .radicand (sumsq),
      .done     (root_done),
      .root     (root_val)
   );

   imd_kalman u_kalman (
      .clock           (clock),
      .reset           (reset),
      .start           (state_ff == ST_ROOT && root_done),
      .mag             (root_val),
      .process_noise   (process_noise_ff),
      .measure_noise   (measure_noise_ff),
      .still_threshold (still_threshold_ff),
      .done            (kal_done),
      .still           (kal_still)
   );

   // Window sums saturate at the limits of the result field.
   for (genvar i = 0; i < 3; i++) begin : g_sum
      always_comb begin
         total_sum[i] = (DISP_WIDTH + 1)'(total_ff[i]) + (DISP_WIDTH + 1)'(disp_step[i]);
         if (total_sum[i][DISP_WIDTH] != total_sum[i][DISP_WIDTH-1])
            total_sat[i] = total_sum[i][DISP_WIDTH] ? {1'b1, {(DISP_WIDTH-1){1'b0}}}
                                                    : {1'b0, {(DISP_WIDTH-1){1'b1}}};
         else
            total_sat[i] = total_sum[i][DISP_WIDTH-1:0];
      end
   end

   assign emit  = !(tick_ff < window_length_ff);
   assign stall = emit && rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_GRAV;
         ST_GRAV:   state_in = ST_RESID;
         ST_RESID:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUMSQ;
         ST_SUMSQ:  state_in = ST_ROOT;
         ST_ROOT:   if (root_done) state_in = ST_KALMAN;
         ST_KALMAN: if (kal_done) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_VEL;
         ST_VEL:    state_in = ST_DISP;
         ST_DISP:   state_in = ST_SUM;
         ST_SUM:    if (!stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) total_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         // A new window result takes the output register; otherwise a taken word clears it.
         if (state_ff == ST_SUM && !stall && emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_chan.ready)
            rsp_valid_ff <= 1'b0;
         if (state_ff == ST_SUM && !stall) begin
            if (emit) begin
               tick_ff      <= '0;
               for (int i = 0; i < 3; i++) total_ff[i] <= '0;
            end else begin
               tick_ff <= tick_ff + 1'b1;
               for (int i = 0; i < 3; i++) total_ff[i] <= total_sat[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUMSQ) band_ff <= band;
      if (state_ff == ST_KALMAN && kal_done) still_ff <= kal_still;
      if (state_ff == ST_SUM && !stall && emit) begin
         for (int i = 0; i < 3; i++) rsp_disp_ff[i] <= total_ff[i];
         rsp_still_ff <= still_ff;
         rsp_band_ff  <= band_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.disp_x        = rsp_disp_ff[0];
   assign rsp_chan.disp_y        = rsp_disp_ff[1];
   assign rsp_chan.disp_z        = rsp_disp_ff[2];
   assign rsp_chan.is_stationary = rsp_still_ff;
   assign rsp_chan.rotation_band = rsp_band_ff;

   `IMD_ASSERT_SAME(a_root_in_step, clock, reset, root_done, state_ff == ST_ROOT, "square root finished outside its step")
   `IMD_ASSERT_SAME(a_kalman_in_step, clock, reset, kal_done, state_ff == ST_KALMAN, "Kalman update finished outside its step")
   `IMD_ASSERT_NEXT(a_emit_waits, clock, reset, state_ff == ST_SUM && stall, state_ff == ST_SUM && rsp_valid_ff, "pending result was overwritten")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for imu_motion_displacement_core: a directed table, then
// random phases under changing register settings, checked against a fixed-point
// predictor or hand-typed results. Depends on imd_pkg, imd_if and the core.
`timescale 1ns / 1ps

module tb_top;
   import imd_pkg::*;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_GRAVITY_COEFF   = 3'd0,
      REG_PROCESS_NOISE   = 3'd1,
      REG_MEASURE_NOISE   = 3'd2,
      REG_STILL_THRESHOLD = 3'd3,
      REG_SLOW_LIMIT      = 3'd4,
      REG_FAST_LIMIT      = 3'd5,
      REG_SLOW_WEIGHT     = 3'd6,
      REG_WINDOW_LENGTH   = 3'd7
   } csr_reg_e;

   // Rotation classes carried in the result word.
   typedef enum logic [1:0] {
      BAND_NONE = 2'd0,
      BAND_SLOW = 2'd1,
      BAND_FAST = 2'd2
   } band_e;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] ax, ay, az, gx, gy, gz;
   } sample_t;

   typedef struct {
      logic signed [DISP_WIDTH-1:0] dx, dy, dz;
      logic still;
      logic [1:0] band;
   } window_sum_t;

   // One row of the directed table. Rows marked known carry a result typed in by hand.
   typedef struct {
      int ax, ay, az, gx, gy, gz;
      bit known;
      bit still;
      band_e band;
   } dir_row_t;

   localparam int CYCLE_LIMIT   = 1500000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int ITEM_TARGET   = 1600;
   localparam int HOLD_CYCLES   = 2500;
   localparam int HOLD_AFTER    = 30;
   localparam longint MAG_Q32   = 64'h0000_0000_8000_0000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [23:0] csr_wdata;

   imd_req_if req ();
   imd_rsp_if rsp ();

   imu_motion_displacement_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: a private copy of the core's registers and filter state.
   longint unsigned reg_val [8];
   longint gravity_est [3];
   longint unsigned kal_var;
   longint kal_est;
   longint prev_sa [3];
   longint prev_vel [3];
   int unsigned tick_cnt;
   longint disp_acc [3];

   window_sum_t pending_sums [$];
   int errors = 0;
   int sums_taken = 0;
   int items_sent = 0;
   longint cycles = 0;

   // Free-running clock; the single reset at the start of the run is driven by the stimulus block.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Clears the private state and loads the register defaults, as a reset does.
   task automatic reset_motion_state();
      reg_val[REG_GRAVITY_COEFF]   = 13107;
      reg_val[REG_PROCESS_NOISE]   = 13107;
      reg_val[REG_MEASURE_NOISE]   = 13107;
      reg_val[REG_STILL_THRESHOLD] = 65536;
      reg_val[REG_SLOW_LIMIT]      = 820;
      reg_val[REG_FAST_LIMIT]      = 1640;
      reg_val[REG_SLOW_WEIGHT]     = 13107;
      reg_val[REG_WINDOW_LENGTH]   = 100;
      for (int i = 0; i < 3; i++) begin
         gravity_est[i] = 0;
         prev_sa[i] = 0;
         prev_vel[i] = 0;
         disp_acc[i] = 0;
      end
      kal_var = 0;
      kal_est = 0;
      tick_cnt = 0;
   endtask

   // Advances the motion estimate by one sample; returns 1 when the sample closes a
   // window, with the emitted totals in sums.
   function automatic bit advance_motion(input sample_t s, output window_sum_t sums);
      longint raw [3];
      longint gyro [3];
      longint resid [3];
      longint a, coeff, mag, k, p, den, thr, weight, sa, v, d, t, gsq, slow2, fast2;
      longint unsigned sumsq, m;
      bit still;
      band_e band;
      raw = '{longint'(s.ax), longint'(s.ay), longint'(s.az)};
      gyro = '{longint'(s.gx), longint'(s.gy), longint'(s.gz)};
      coeff = reg_val[REG_GRAVITY_COEFF] > 65536 ? 65536 : reg_val[REG_GRAVITY_COEFF];
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         a = (raw[i] * longint'(ACCEL_MUL) + 32768) >>> 16;
         gravity_est[i] += ((a - gravity_est[i]) * coeff + 32768) >>> 16;
         resid[i] = a - gravity_est[i];
         m = resid[i] < 0 ? -resid[i] : resid[i];
         sumsq += m * m;
      end
      mag = int_sqrt(sumsq);

      // Scalar Kalman filter on the residual magnitude; the gain is zero when its
      // denominator vanishes.
      p = kal_var + reg_val[REG_PROCESS_NOISE];
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      den = p + reg_val[REG_MEASURE_NOISE];
      k = den != 0 ? (p <<< 16) / den : 0;
      kal_est += ((mag - kal_est) * k + 32768) >>> 16;
      kal_var = ((65536 - k) * p) >> 16;
      thr = longint'(reg_val[REG_STILL_THRESHOLD]) <<< 8;
      still = kal_est < thr;

      gsq = 0;
      for (int i = 0; i < 3; i++) gsq += gyro[i] * gyro[i];
      slow2 = reg_val[REG_SLOW_LIMIT] * reg_val[REG_SLOW_LIMIT];
      fast2 = reg_val[REG_FAST_LIMIT] * reg_val[REG_FAST_LIMIT];
      if (gsq < slow2) band = BAND_NONE;
      else if (gsq < fast2) band = BAND_SLOW;
      else band = BAND_FAST;

      if (still || band == BAND_FAST) weight = 0;
      else if (band == BAND_NONE) weight = 65536;
      else weight = reg_val[REG_SLOW_WEIGHT] > 65536 ? 65536 : reg_val[REG_SLOW_WEIGHT];

      // Two trapezoidal steps with a half step of 5 ms.
      for (int i = 0; i < 3; i++) begin
         sa = (resid[i] * weight + 32768) >>> 16;
         v = ((prev_sa[i] + sa) * longint'(HALF_DT_Q32) + MAG_Q32) >>> 32;
         d = (prev_vel[i] + v + 1) >>> 1;
         prev_sa[i] = sa;
         prev_vel[i] = v;
         resid[i] = d;
      end

      if (tick_cnt < reg_val[REG_WINDOW_LENGTH]) begin
         tick_cnt++;
         for (int i = 0; i < 3; i++) begin
            t = disp_acc[i] + resid[i];
            if (t > 64'sd17179869183) t = 64'sd17179869183;
            if (t < -64'sd17179869184) t = -64'sd17179869184;
            disp_acc[i] = t;
         end
         return 1'b0;
      end
      sums.dx = disp_acc[0][DISP_WIDTH-1:0];
      sums.dy = disp_acc[1][DISP_WIDTH-1:0];
      sums.dz = disp_acc[2][DISP_WIDTH-1:0];
      sums.still = still;
      sums.band = band;
      for (int i = 0; i < 3; i++) disp_acc[i] = 0;
      tick_cnt = 0;
      return 1'b1;
   endfunction

   // Register writes happen only while the core is idle. The enable drops for one
   // cycle after each write so that writes never meet in the same time step.
   task automatic write_reg(input csr_reg_e idx, input longint unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[23:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_GRAVITY_COEFF, REG_SLOW_WEIGHT: reg_val[idx] = value & 64'h1FFFF;
         REG_SLOW_LIMIT, REG_FAST_LIMIT:     reg_val[idx] = value & 64'hFFFF;
         REG_WINDOW_LENGTH:                  reg_val[idx] = value & 64'h3FF;
         default:                            reg_val[idx] = value & 64'hFFFFFF;
      endcase
      @(posedge clock);
   endtask

   // Waits until every expected window has been taken, then lets a sample that is still
   // in flight, and causes no window, work its way through.
   task automatic wait_idle();
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offers one word, holding valid high across back-to-back words, and predicts its
   // outcome once it has been accepted. A known row replaces the predicted window.
   task automatic send_sample(input sample_t s, input bit known, input window_sum_t typed);
      int gap;
      int pick;
      window_sum_t sums;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 4);
      else gap = $urandom_range(20, 120);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.accel_x <= s.ax;
      req.accel_y <= s.ay;
      req.accel_z <= s.az;
      req.gyro_x <= s.gx;
      req.gyro_y <= s.gy;
      req.gyro_z <= s.gz;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      if (advance_motion(s, sums)) pending_sums.push_back(known ? typed : sums);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] rand_word();
      return SAMPLE_WIDTH'($urandom);
   endfunction

   // Random sample: mostly quiet or moving device sequences, some random words, some
   // extremes and some gyro values just around the band limits.
   function automatic sample_t make_sample(input int style);
      sample_t s;
      int pick;
      logic [15:0] lim;
      pick = $urandom_range(0, 9);
      if (style == 0 && pick < 7) begin
         s.ax = $urandom_range(0, 80) - 40;
         s.ay = $urandom_range(0, 80) - 40;
         s.az = 16384 + $urandom_range(0, 80) - 40;
         s.gx = $urandom_range(0, 600) - 300;
         s.gy = $urandom_range(0, 600) - 300;
         s.gz = $urandom_range(0, 600) - 300;
      end else if (pick < 6) begin
         s.ax = $urandom_range(0, 16000) - 8000;
         s.ay = $urandom_range(0, 16000) - 8000;
         s.az = 16384 + $urandom_range(0, 16000) - 8000;
         s.gx = $urandom_range(0, 3000) - 1500;
         s.gy = $urandom_range(0, 3000) - 1500;
         s.gz = $urandom_range(0, 3000) - 1500;
      end else if (pick < 8) begin
         s = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
      end else if (pick < 9) begin
         s.ax = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.ay = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.az = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd1;
         s.gx = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         s.gy = $urandom_range(0, 1) ? 16'sh7FFF : 16'sd0;
         s.gz = $urandom_range(0, 1) ? 16'sh8000 : 16'sd0;
      end else begin
         lim = $urandom_range(0, 1) ? 16'(reg_val[REG_SLOW_LIMIT])
                                    : 16'(reg_val[REG_FAST_LIMIT]);
         s.ax = $urandom_range(0, 4000) - 2000;
         s.ay = $urandom_range(0, 4000) - 2000;
         s.az = 16384;
         s.gx = (lim > 16'h7FFE) ? 16'sh7FFF : lim - 1 + $urandom_range(0, 2);
         if ($urandom_range(0, 1)) s.gx = -s.gx;
         s.gy = 0;
         s.gz = 0;
      end
      return s;
   endfunction

   function automatic longint unsigned pick_value(input longint unsigned lo,
                                                  input longint unsigned hi);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return lo;
      if (pick == 1) return hi;
      return lo + ($urandom % (hi - lo + 1));
   endfunction

   // Stimulus: directed table, then random phases under varied settings.
   initial begin
      dir_row_t dir_tab [22];
      sample_t s;
      window_sum_t typed;
      int phase_items;
      int phase;
      int style;
      dir_tab = '{
         // Zero window: every word emits zero totals.
         '{0, 0, 0, 0, 0, 0, 1, 1, BAND_NONE},
         '{0, 0, 0, 32767, 32767, 32767, 1, 1, BAND_FAST},
         '{0, 0, 0, -32768, -32768, -32768, 1, 1, BAND_FAST},
         '{32767, 0, 0, 0, 0, 0, 0, 0, BAND_NONE},
         '{-32768, -32768, -32768, 0, 0, 0, 0, 0, BAND_NONE},
         '{32767, 32767, 32767, 100, -100, 5, 0, 0, BAND_NONE},
         '{0, 0, 16384, 0, 0, 0, 0, 0, BAND_NONE},
         // Window of two, default limits: gyro magnitudes either side of both limits.
         '{1000, -2000, 16384, 819, 0, 0, 0, 0, BAND_NONE},
         '{1000, -2000, 16384, 820, 0, 0, 0, 0, BAND_NONE},
         '{-3000, 2500, 16000, 0, -1639, 0, 0, 0, BAND_NONE},
         '{-3000, 2500, 16000, 0, 0, 1640, 0, 0, BAND_NONE},
         '{8000, 8000, 8000, 500, 500, 500, 0, 0, BAND_NONE},
         '{-8000, 0, 24000, -600, 0, -600, 0, 0, BAND_NONE},
         '{32767, -32768, 32767, 0, 0, 0, 0, 0, BAND_NONE},
         '{-32768, 32767, -32768, 0, 0, 0, 0, 0, BAND_NONE},
         '{0, 0, 16384, 0, 0, 0, 0, 0, BAND_NONE},
         '{0, 0, 16384, 0, 0, 0, 0, 0, BAND_NONE},
         '{5, -5, 16390, 1, -1, 1, 0, 0, BAND_NONE},
         '{12345, -12345, 321, 2000, -2000, 10, 0, 0, BAND_NONE},
         '{-1, -1, -1, -1, -1, -1, 0, 0, BAND_NONE},
         '{1, 1, 1, 1, 1, 1, 0, 0, BAND_NONE},
         '{0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE}
      };
      reset_motion_state();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_GRAVITY_COEFF;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.accel_x = '0;
      req.accel_y = '0;
      req.accel_z = '0;
      req.gyro_x = '0;
      req.gyro_y = '0;
      req.gyro_z = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_WINDOW_LENGTH, 0);
      for (int r = 0; r < 22; r++) begin
         if (r == 7) begin
            req.valid <= 1'b0;
            wait_idle();
            write_reg(REG_WINDOW_LENGTH, 2);
         end
         s = '{dir_tab[r].ax, dir_tab[r].ay, dir_tab[r].az,
               dir_tab[r].gx, dir_tab[r].gy, dir_tab[r].gz};
         typed = '{'0, '0, '0, dir_tab[r].still, dir_tab[r].band};
         send_sample(s, dir_tab[r].known, typed);
      end

      // Random phases. The first keeps one-word windows so that results come thick and
      // the long receiver hold-off backs the core up; phase four uses the longest window.
      // Phases start without draining the partial window, so a shorter window length
      // often lands below the word count already reached.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         req.valid <= 1'b0;
         wait_idle();
         if (phase == 0) begin
            write_reg(REG_WINDOW_LENGTH, 1);
         end else begin
            write_reg(REG_GRAVITY_COEFF, pick_value(0, 131071));
            write_reg(REG_PROCESS_NOISE, phase == 2 ? 0 : pick_value(0, 24'hFFFFFF));
            write_reg(REG_MEASURE_NOISE, phase == 2 ? 0 : pick_value(1, 24'hFFFFFF));
            write_reg(REG_STILL_THRESHOLD,
                      $urandom_range(0, 2) == 0 ? pick_value(0, 24'hFFFFFF)
                                                : pick_value(0, 1 << 20));
            write_reg(REG_SLOW_LIMIT, $urandom_range(0, 2) == 0 ? pick_value(0, 65535)
                                                                : pick_value(0, 3000));
            write_reg(REG_FAST_LIMIT, $urandom_range(0, 2) == 0 ? pick_value(0, 65535)
                                                                : pick_value(0, 3000));
            write_reg(REG_SLOW_WEIGHT, pick_value(0, 131071));
            if (phase == 4) write_reg(REG_WINDOW_LENGTH, 1023);
            else if ($urandom_range(0, 7) == 0) write_reg(REG_WINDOW_LENGTH, 0);
            else write_reg(REG_WINDOW_LENGTH, $urandom_range(1, 8));
         end
         phase_items = (phase == 4) ? 1030 : $urandom_range(40, 120);
         style = $urandom_range(0, 1);
         for (int n = 0; n < phase_items; n++) begin
            s = make_sample(style);
            send_sample(s, 1'b0, typed);
         end
         phase++;
      end
      req.valid <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result side: random stalls with calm stretches, one long hold-off, and a field by
   // field comparison of every word taken against the oldest expected window.
   initial begin
      window_sum_t want;
      int stall_left;
      int hold_left;
      bit held;
      int calm_left;
      rsp.ready = 1'b0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
      calm_left = 0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            if (pending_sums.size() == 0) begin
               $display("%0t: window word with none expected: x=%0d y=%0d z=%0d", $time,
                        rsp.disp_x, rsp.disp_y, rsp.disp_z);
               errors++;
            end else begin
               want = pending_sums.pop_front();
               if (rsp.disp_x !== want.dx) begin
                  $display("%0t: disp_x expected %0d actual %0d", $time, want.dx, rsp.disp_x);
                  errors++;
               end
               if (rsp.disp_y !== want.dy) begin
                  $display("%0t: disp_y expected %0d actual %0d", $time, want.dy, rsp.disp_y);
                  errors++;
               end
               if (rsp.disp_z !== want.dz) begin
                  $display("%0t: disp_z expected %0d actual %0d", $time, want.dz, rsp.disp_z);
                  errors++;
               end
               if (rsp.is_stationary !== want.still) begin
                  $display("%0t: is_stationary expected %0d actual %0d", $time,
                           want.still, rsp.is_stationary);
                  errors++;
               end
               if (rsp.rotation_band !== want.band) begin
                  $display("%0t: rotation_band expected %0d actual %0d", $time,
                           want.band, rsp.rotation_band);
                  errors++;
               end
            end
            sums_taken++;
         end
         if (!held && sums_taken == HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (calm_left > 0) calm_left--;
         else if ($urandom_range(0, 999) == 0) calm_left = $urandom_range(200, 800);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (calm_left == 0 && $urandom_range(0, 9) < 3) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                    : $urandom_range(0, 3);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/imd_pkg.sv
hdl/imd_if.sv
hdl/imd_axis_lane.sv
hdl/imd_isqrt.sv
hdl/imd_kalman.sv
hdl/imu_motion_displacement_core.sv
test/tb_top.sv
